FILE: rtl/multi_generator_random_bank_defines.svh
// Assertion macros for the random generator bank.
`ifndef MULTI_GENERATOR_RANDOM_BANK_DEFINES_SVH
`define MULTI_GENERATOR_RANDOM_BANK_DEFINES_SVH
// Property that holds in the cycle after the trigger.
`define MGRB_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("%m: check failed");
// Property that holds in the same cycle.
`define MGRB_ASSERT_NOW(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("%m: check failed");
`endif

FILE: rtl/mgrb_pkg.sv
// Package: types, operation codes and constants of the random generator bank.
package mgrb_pkg;
    localparam int unsigned TableDepth = 256;
    localparam int unsigned IdxW       = $clog2(TableDepth);

    typedef enum logic [3:0] {
        t_op_mwc   = 4'd0,
        t_op_shr3  = 4'd1,
        t_op_cong  = 4'd2,
        t_op_fib   = 4'd3,
        t_op_kiss  = 4'd4,
        t_op_lfib4 = 4'd5,
        t_op_swb   = 4'd6,
        t_op_load  = 4'd7,
        t_op_hash  = 4'd8
    } t_op;

    typedef enum logic [3:0] {
        S_RESET, S_IDLE, S_HASH, S_FILL, S_RD1, S_RD2, S_RD3, S_RD4, S_WR, S_OUT
    } t_state;

    // Table port request from controller.
    typedef struct packed {
        logic            we;
        logic [IdxW-1:0] addr;
        logic [31:0]     wdata;
    } t_tbl_req;

    localparam logic [31:0] MwcHighSeed = 32'd362436069;
    localparam logic [31:0] MwcLowSeed  = 32'd521288629;
    localparam logic [31:0] ShrSeed     = 32'd123456789;
    localparam logic [31:0] CongSeed    = 32'd380116160;
    localparam logic [31:0] FibASeed    = 32'd224466889;
    localparam logic [31:0] FibBSeed    = 32'd7584631;

    localparam logic [2:0] RegMwcHigh = 3'd0;
    localparam logic [2:0] RegMwcLow  = 3'd1;
    localparam logic [2:0] RegShr     = 3'd2;
    localparam logic [2:0] RegCong    = 3'd3;
    localparam logic [2:0] RegFibA    = 3'd4;
    localparam logic [2:0] RegFibB    = 3'd5;

    function automatic logic [31:0] f_shr3(input logic [31:0] v);
        logic [31:0] a;
        logic [31:0] b;
        a = v ^ (v << 17);
        b = a ^ (a >> 13);
        return b ^ (b << 5);
    endfunction

    // Half of one hash per call, three steps each; f_hash_a then f_hash_b chain the six.
    function automatic logic [31:0] f_hash_a(input logic [31:0] v);
        logic [31:0] a;
        logic [31:0] b;
        a = (v + 32'h7ed55d16) + (v << 12);
        b = (a ^ 32'hc761c23c) ^ (a >> 19);
        return (b + 32'h165667b1) + (b << 5);
    endfunction

    function automatic logic [31:0] f_hash_b(input logic [31:0] v);
        logic [31:0] a;
        logic [31:0] b;
        a = (v + 32'hd3a2646c) ^ (v << 9);
        b = (a + 32'hfd7046c5) + (a << 3);
        return (b ^ 32'hb55a4f09) ^ (b >> 16);
    endfunction
endpackage

FILE: rtl/mgrb_table.sv
// Lag table: 256 x 32 synchronous single-port memory, registered read.
module mgrb_table (
    input  logic                 i_clk,
    input  mgrb_pkg::t_tbl_req   i_req,
    output logic [31:0]          o_rdata
);
    logic [31:0] r_mem [mgrb_pkg::TableDepth];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.addr];
    end
endmodule

FILE: rtl/mgrb_gens.sv
// Scalar generators: MWC, SHR3, CONG and FIB registers with a step strobe each, plus a KISS output.
module mgrb_gens (
    input  logic        i_clk,
    input  logic        i_ld,
    input  logic [31:0] i_s0,
    input  logic [31:0] i_s1,
    input  logic [31:0] i_s2,
    input  logic [31:0] i_s3,
    input  logic [31:0] i_s4,
    input  logic [31:0] i_s5,
    input  logic        i_step_mwc,
    input  logic        i_step_shr,
    input  logic        i_step_cong,
    input  logic        i_step_fib,
    output logic [31:0] o_mwc,
    output logic [31:0] o_shr,
    output logic [31:0] o_cong,
    output logic [31:0] o_fib,
    output logic [31:0] o_kiss
);
    logic [31:0] r_mh, r_ml, r_shr, r_cong, r_fa, r_fb;
    logic [31:0] n_mh, n_ml, n_shr, n_cong, n_fb;

    always_comb begin
        n_mh   = 32'(32'd36969 * {16'd0, r_mh[15:0]}) + {16'd0, r_mh[31:16]};
        n_ml   = 32'(32'd18000 * {16'd0, r_ml[15:0]}) + {16'd0, r_ml[31:16]};
        n_shr  = mgrb_pkg::f_shr3(r_shr);
        n_cong = 32'(32'd69069 * r_cong) + 32'd1234567;
        n_fb   = r_fa + r_fb;
        o_mwc  = {n_mh[15:0], 16'd0} + n_ml;
        o_shr  = n_shr;
        o_cong = n_cong;
        o_fib  = r_fb;
        o_kiss = (o_mwc ^ n_cong) + n_shr;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_mh <= i_s0; r_ml <= i_s1; r_shr <= i_s2;
            r_cong <= i_s3; r_fa <= i_s4; r_fb <= i_s5;
        end else begin
            if (i_step_mwc) begin
                r_mh <= n_mh;
                r_ml <= n_ml;
            end
            if (i_step_shr) r_shr <= n_shr;
            if (i_step_cong) r_cong <= n_cong;
            if (i_step_fib) begin
                r_fa <= r_fb;
                r_fb <= n_fb;
            end
        end
    end
endmodule

FILE: rtl/multi_generator_random_bank.sv
// Top level of the random generator bank: controller, seed registers, table and generators.
// Bank of 32-bit generators (MWC, SHR3, CONG, FIB, KISS, LFIB4, SWB) under
// one controller; each item picks an operation by i_func and returns one word.
// MWC/SHR3/CONG/FIB/KISS and unused codes are answered from the idle state.
// SWB reads two table words and writes one back; LFIB4 reads four table words
// through the single table port and writes one back. Load (func 7) fills the
// 256-entry table with one KISS draw per cycle; hash seed (func 8) first runs
// six chained hashes, each split in two halves, then the seed load and fill.
// After reset the block runs the same load with the power-up seeds before it
// accepts items; configuration writes are taken throughout. Result sits in an
// output register; the next item is accepted once it leaves, so no new item is
// taken while one is in progress or its result waits.
module multi_generator_random_bank (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_func,
    input  logic [31:0] i_seed_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_value
);
`include "multi_generator_random_bank_defines.svh"

    localparam int unsigned IdxW = mgrb_pkg::IdxW;

    mgrb_pkg::t_state r_state, n_state;
    logic [31:0] r_seed [6];
    logic [31:0] r_hv [6];          // hashed seed chain
    logic [2:0]  r_hcnt, n_hcnt;
    logic        r_use_hash, n_use_hash;
    logic [IdxW:0] r_cnt, n_cnt;    // fill counter, top bit = done
    logic [IdxW-1:0] r_idx, n_idx;
    logic [3:0]  r_func, n_func;
    logic [31:0] r_acc, n_acc;      // LFIB4 sum / SWB minuend
    logic [31:0] r_min, r_sub;
    logic        r_bor;
    logic        r_ovalid, n_ovalid;
    logic [31:0] r_val, n_val;

    mgrb_pkg::t_tbl_req w_req;
    logic [31:0] w_rdata;
    logic        w_ld;
    logic        w_smwc, w_sshr, w_scong, w_sfib;
    logic [31:0] w_mwc, w_shr, w_cong, w_fib, w_kiss;
    logic [31:0] w_s [6];
    logic        w_swb_upd;
    logic [31:0] w_swb_sub;

    mgrb_table u_table (.i_clk(i_clk), .i_req(w_req), .o_rdata(w_rdata));

    always_comb begin
        for (int k = 0; k < 6; k++) w_s[k] = r_use_hash ? r_hv[k] : r_seed[k];
    end

    mgrb_gens u_gens (
        .i_clk(i_clk), .i_ld(w_ld),
        .i_s0(w_s[0]), .i_s1(w_s[1]), .i_s2(w_s[2]),
        .i_s3(w_s[3]), .i_s4(w_s[4]), .i_s5(w_s[5]),
        .i_step_mwc(w_smwc), .i_step_shr(w_sshr),
        .i_step_cong(w_scong), .i_step_fib(w_sfib),
        .o_mwc(w_mwc), .o_shr(w_shr), .o_cong(w_cong), .o_fib(w_fib), .o_kiss(w_kiss)
    );

    // Seed registers; reset gives the power-up seeds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed[0] <= mgrb_pkg::MwcHighSeed;
            r_seed[1] <= mgrb_pkg::MwcLowSeed;
            r_seed[2] <= mgrb_pkg::ShrSeed;
            r_seed[3] <= mgrb_pkg::CongSeed;
            r_seed[4] <= mgrb_pkg::FibASeed;
            r_seed[5] <= mgrb_pkg::FibBSeed;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mgrb_pkg::RegMwcHigh: r_seed[0] <= i_cfg_data;
                mgrb_pkg::RegMwcLow:  r_seed[1] <= i_cfg_data;
                mgrb_pkg::RegShr:     r_seed[2] <= i_cfg_data;
                mgrb_pkg::RegCong:    r_seed[3] <= i_cfg_data;
                mgrb_pkg::RegFibA:    r_seed[4] <= i_cfg_data;
                mgrb_pkg::RegFibB:    r_seed[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hash chain: each step one hash, split over halves of one register stage.
    logic [31:0] r_hmid;
    logic        r_hhalf;
    always_ff @(posedge i_clk) begin
        if (r_state == mgrb_pkg::S_IDLE) begin
            r_hmid  <= mgrb_pkg::f_hash_a(i_seed_word);
            r_hhalf <= 1'b1;
        end else if (r_state == mgrb_pkg::S_HASH) begin
            if (r_hhalf) begin
                r_hv[r_hcnt] <= mgrb_pkg::f_hash_b(r_hmid);
                r_hhalf <= 1'b0;
            end else begin
                r_hmid  <= mgrb_pkg::f_hash_a(r_hv[r_hcnt - 3'd1]);
                r_hhalf <= 1'b1;
            end
        end
    end

    assign o_stall = (r_state != mgrb_pkg::S_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_value = r_val;

    wire w_acc = i_valid && !o_stall;
    assign w_swb_sub = w_rdata + {31'd0, w_swb_upd ? (r_min < r_sub) : r_bor};

    always_comb begin
        n_state = r_state; n_hcnt = r_hcnt; n_use_hash = r_use_hash;
        n_cnt = r_cnt; n_idx = r_idx; n_func = r_func; n_acc = r_acc;
        n_ovalid = r_ovalid && i_stall; n_val = r_val;
        w_req = '{we: 1'b0, addr: r_idx, wdata: r_acc};
        w_ld = 1'b0; w_smwc = 1'b0; w_sshr = 1'b0; w_scong = 1'b0; w_sfib = 1'b0;
        w_swb_upd = 1'b0;
        case (r_state)
            mgrb_pkg::S_RESET: begin
                // r_func keeps the op that got here: a hash answers, a power-up load does not
                w_ld = 1'b1; n_use_hash = 1'b0; n_cnt = '0;
                n_state = mgrb_pkg::S_FILL;
            end
            mgrb_pkg::S_IDLE: begin
                if (w_acc) begin
                    n_func = i_func;
                    n_val = '0;
                    case (i_func)
                        mgrb_pkg::t_op_mwc:  begin w_smwc = 1'b1; n_val = w_mwc; end
                        mgrb_pkg::t_op_shr3: begin w_sshr = 1'b1; n_val = w_shr; end
                        mgrb_pkg::t_op_cong: begin w_scong = 1'b1; n_val = w_cong; end
                        mgrb_pkg::t_op_fib:  begin w_sfib = 1'b1; n_val = w_fib; end
                        mgrb_pkg::t_op_kiss: begin
                            w_smwc = 1'b1; w_sshr = 1'b1; w_scong = 1'b1; n_val = w_kiss;
                        end
                        mgrb_pkg::t_op_lfib4, mgrb_pkg::t_op_swb: begin
                            n_idx = r_idx + 1'b1;
                            n_state = mgrb_pkg::S_RD1;
                        end
                        mgrb_pkg::t_op_load: begin
                            n_use_hash = 1'b0; n_state = mgrb_pkg::S_FILL; n_cnt = '0;
                            w_ld = 1'b1;
                        end
                        mgrb_pkg::t_op_hash: begin
                            n_use_hash = 1'b1; n_hcnt = '0; n_state = mgrb_pkg::S_HASH;
                        end
                        default: ;
                    endcase
                    if (n_state == mgrb_pkg::S_IDLE) n_ovalid = 1'b1;
                end
            end
            mgrb_pkg::S_HASH: begin
                if (r_hhalf) begin
                    if (r_hcnt == 3'd5) begin
                        n_state = mgrb_pkg::S_RESET;
                    end else begin
                        n_hcnt = r_hcnt + 3'd1;
                    end
                end
            end
            mgrb_pkg::S_FILL: begin
                if (r_use_hash && r_cnt == '0 && r_func == mgrb_pkg::t_op_load) begin
                    w_ld = 1'b0;
                end
                w_req = '{we: 1'b1, addr: r_cnt[IdxW-1:0], wdata: w_kiss};
                w_smwc = 1'b1; w_sshr = 1'b1; w_scong = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[IdxW-1:0] == '1) begin
                    n_idx = '0; n_state = mgrb_pkg::S_IDLE;
                    if (r_func == mgrb_pkg::t_op_hash || r_func == mgrb_pkg::t_op_load) begin
                        n_val = '0; n_ovalid = 1'b1;
                    end
                end
            end
            mgrb_pkg::S_RD1: begin
                // first read: i (lfib4) or i+34 (swb)
                w_req.addr = (r_func == mgrb_pkg::t_op_swb) ? r_idx + IdxW'(34) : r_idx;
                n_state = mgrb_pkg::S_RD2;
            end
            mgrb_pkg::S_RD2: begin
                w_req.addr = (r_func == mgrb_pkg::t_op_swb) ? r_idx + IdxW'(19)
                                                            : r_idx + IdxW'(58);
                n_acc = w_rdata;
                n_state = (r_func == mgrb_pkg::t_op_swb) ? mgrb_pkg::S_WR : mgrb_pkg::S_RD3;
            end
            mgrb_pkg::S_RD3: begin
                w_req.addr = r_idx + IdxW'(119);
                n_acc = r_acc + w_rdata;
                n_state = mgrb_pkg::S_RD4;
            end
            mgrb_pkg::S_RD4: begin
                w_req.addr = r_idx + IdxW'(178);
                n_acc = r_acc + w_rdata;
                n_state = mgrb_pkg::S_WR;
            end
            mgrb_pkg::S_WR: begin
                if (r_func == mgrb_pkg::t_op_swb) begin
                    w_swb_upd = 1'b1;
                    n_acc = r_acc - w_swb_sub;
                end else begin
                    n_acc = r_acc + w_rdata;
                end
                n_state = mgrb_pkg::S_OUT;
            end
            mgrb_pkg::S_OUT: begin
                w_req = '{we: 1'b1, addr: r_idx, wdata: r_acc};
                n_val = r_acc; n_ovalid = 1'b1; n_state = mgrb_pkg::S_IDLE;
            end
            default: n_state = mgrb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mgrb_pkg::S_RESET; r_ovalid <= 1'b0; r_idx <= '0;
            r_min <= '0; r_sub <= '0; r_bor <= 1'b0; r_use_hash <= 1'b0;
            r_cnt <= '0; r_hcnt <= '0; r_func <= mgrb_pkg::t_op_mwc;
        end else begin
            r_state <= n_state; r_ovalid <= n_ovalid; r_idx <= n_idx;
            r_use_hash <= n_use_hash; r_cnt <= n_cnt; r_hcnt <= n_hcnt; r_func <= n_func;
            if (w_swb_upd) begin
                r_bor <= (r_min < r_sub);
                r_min <= r_acc;
                r_sub <= w_swb_sub;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_val <= n_val;
    end

    `MGRB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_value))
    `MGRB_ASSERT_NOW(a_busy_stall, i_clk, i_rst_n, r_state != mgrb_pkg::S_IDLE, o_stall)
    `MGRB_ASSERT_NEXT(a_swb_wr, i_clk, i_rst_n, r_state == mgrb_pkg::S_WR,
                      r_state == mgrb_pkg::S_OUT)
endmodule
